FILE: sv/gyro_autorange_scaler_core_defines.svh
// Assertion macros shared by the checker.
`ifndef GYRO_AUTORANGE_SCALER_CORE_DEFINES_SVH
`define GYRO_AUTORANGE_SCALER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gar check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gar check failed");

`endif

FILE: sv/gar_pkg.sv
`timescale 1ns / 1ps

package gar_pkg;

    localparam int AXIS_MAX = 3;

    localparam int RAW_W   = 16;
    localparam int RATE_W  = 24;
    localparam int SCALE_W = 24;
    localparam int LIMIT_W = 15;
    localparam int RANGE_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [RANGE_W-1:0] RANGE_250  = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_500  = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_2000 = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_BAD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_AUTO_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_HIGH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_MID   = 3'd7;

    localparam logic [SCALE_W-1:0] SCALE_LOW_RST  = 24'd655910;
    localparam logic [SCALE_W-1:0] SCALE_MID_RST  = 24'd1311820;
    localparam logic [SCALE_W-1:0] SCALE_HIGH_RST = 24'd5247280;
    localparam logic [LIMIT_W-1:0] SAT_LIMIT_RST  = 15'd28571;
    localparam logic [LIMIT_W-1:0] DOWN_HIGH_RST  = 15'd7142;
    localparam logic [LIMIT_W-1:0] DOWN_MID_RST   = 15'd14704;

    typedef struct packed {
        logic signed [RAW_W-1:0] x_raw;
        logic signed [RAW_W-1:0] y_raw;
        logic signed [RAW_W-1:0] z_raw;
    } t_in_item;

    typedef struct packed {
        logic signed [RATE_W-1:0] x_rate;
        logic signed [RATE_W-1:0] y_rate;
        logic signed [RATE_W-1:0] z_rate;
        logic [RANGE_W-1:0]       range_used;
        logic [RANGE_W-1:0]       range_next;
        logic                     range_changed;
    } t_out_item;

    // What one lane reports to the range unit.
    typedef struct packed {
        logic over_sat;
        logic inside_down;
    } t_lane_flags;

    // Pipeline load strobes shared by all lanes.
    typedef struct packed {
        logic load1;
        logic load2;
    } t_pipe_ctl;

endpackage

FILE: sv/gar_lane.sv
`timescale 1ns / 1ps

module gar_lane (
    input  logic                              i_clk,
    input  gar_pkg::t_pipe_ctl                i_ctl,
    input  logic signed [gar_pkg::RAW_W-1:0]  i_raw,
    input  logic [gar_pkg::LIMIT_W-1:0]       i_sat_limit,
    input  logic [gar_pkg::LIMIT_W-1:0]       i_down_limit,
    input  logic [gar_pkg::SCALE_W-1:0]       i_scale,
    output gar_pkg::t_lane_flags              o_flags,
    output logic signed [gar_pkg::RATE_W-1:0] o_rate
);
    import gar_pkg::*;

    localparam int PROD_W = RAW_W + SCALE_W + 1;

    logic signed [RAW_W:0]    w_v;
    logic signed [RAW_W:0]    w_sat;
    logic signed [RAW_W:0]    w_down;
    logic signed [RAW_W-1:0]  r_raw;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [RATE_W-1:0] r_rate;

    assign w_v    = {i_raw[RAW_W-1], i_raw};
    assign w_sat  = {2'b00, i_sat_limit};
    assign w_down = {2'b00, i_down_limit};

    assign o_flags.over_sat    = (w_v > w_sat) || (w_v < -w_sat);
    assign o_flags.inside_down = (w_v < w_down) && (w_v > -w_down);

    // Scale is unsigned; the arithmetic shift by 16 is floor rounding.
    assign w_prod = PROD_W'(r_raw) * PROD_W'($signed({1'b0, i_scale}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load1) begin
            r_raw <= i_raw;
        end
        if (i_ctl.load2) begin
            r_rate <= w_prod[RATE_W+15:16];
        end
    end

    assign o_rate = r_rate;

endmodule

FILE: sv/gar_range.sv
`timescale 1ns / 1ps

module gar_range (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [gar_pkg::RANGE_W-1:0]   i_load_value,
    input  logic                          i_accept,
    input  logic                          i_auto_en,
    input  gar_pkg::t_lane_flags          i_flags [gar_pkg::AXIS_MAX],
    output logic [gar_pkg::RANGE_W-1:0]   o_range,
    output logic [gar_pkg::RANGE_W-1:0]   o_next,
    output logic                          o_changed
);
    import gar_pkg::*;

    logic [RANGE_W-1:0] r_range;
    logic [RANGE_W-1:0] n_range;
    logic               w_any_sat;
    logic               w_all_inside;

    always_comb begin
        w_any_sat    = 1'b0;
        w_all_inside = 1'b1;
        for (int i = 0; i < AXIS_MAX; i++) begin
            w_any_sat    = w_any_sat | i_flags[i].over_sat;
            w_all_inside = w_all_inside & i_flags[i].inside_down;
        end
    end

    always_comb begin
        n_range = r_range;
        if (i_auto_en) begin
            if (w_any_sat) begin
                unique case (r_range)
                    RANGE_250: n_range = RANGE_500;
                    RANGE_500: n_range = RANGE_2000;
                    default:   n_range = r_range;
                endcase
            end else if (w_all_inside) begin
                unique case (r_range)
                    RANGE_2000: n_range = RANGE_500;
                    RANGE_500:  n_range = RANGE_250;
                    default:    n_range = r_range;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RANGE_250;
        end else if (i_load) begin
            r_range <= (i_load_value == RANGE_BAD) ? RANGE_2000 : i_load_value;
        end else if (i_accept) begin
            r_range <= n_range;
        end
    end

    assign o_range   = r_range;
    assign o_next    = n_range;
    assign o_changed = (n_range != r_range);

endmodule

FILE: sv/gyro_autorange_scaler_core.sv
`timescale 1ns / 1ps
// Three-axis gyro rate scaler with automatic range selection.
// Input channel: i_in_valid / o_in_stall carry one raw x/y/z sample per item.
// Output channel: o_out_valid / i_out_stall carry the signed 24-bit rates, the
// range that scaled the sample, the next sample's range and a range-step flag.
// Config: write i_cfg_wdata to register i_cfg_index when i_cfg_wr_en is high;
// writing the initial-range register loads the current range (code 3 -> 2000).
// Throughput: one item per cycle while the output is not stalled. Each axis
// lane compares its sample against the limits as it is accepted, and the range
// register moves in that same cycle, so the next item already sees the new
// range. An accepted item passes the capture stage, then the 16x24 multiply
// stage per lane (raw sample times the unsigned Q8.16 scale).
// Reset: synchronous, active low; pipeline empties, range goes to 250 dps
// and the configuration registers return to their defaults.
// Stall: the output register holds its item while i_out_stall is high; an
// empty capture stage still takes one more item, after which o_in_stall rises.
module gyro_autorange_scaler_core #(
    parameter int AXIS_COUNT = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  gar_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output gar_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_wr_en,
    input  logic [gar_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gar_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import gar_pkg::*;

    logic               r_auto_en;
    logic [SCALE_W-1:0] r_scale_low;
    logic [SCALE_W-1:0] r_scale_mid;
    logic [SCALE_W-1:0] r_scale_high;
    logic [LIMIT_W-1:0] r_sat_limit;
    logic [LIMIT_W-1:0] r_down_high;
    logic [LIMIT_W-1:0] r_down_mid;

    logic               r_v1;
    logic               r_v2;
    logic [SCALE_W-1:0] r_scale1;
    logic [RANGE_W-1:0] r_used1;
    logic [RANGE_W-1:0] r_next1;
    logic               r_changed1;
    logic [RANGE_W-1:0] r_used2;
    logic [RANGE_W-1:0] r_next2;
    logic               r_changed2;

    logic               w_load1;
    logic               w_load2;
    logic               w_accept;
    t_pipe_ctl          w_ctl;

    logic [RANGE_W-1:0] w_range;
    logic [RANGE_W-1:0] w_next;
    logic               w_changed;
    logic [SCALE_W-1:0] w_scale;
    logic [LIMIT_W-1:0] w_down;

    logic signed [RAW_W-1:0]  w_raw  [AXIS_MAX];
    logic signed [RATE_W-1:0] w_rate [AXIS_MAX];
    t_lane_flags              w_flags[AXIS_MAX];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_en    <= 1'b0;
            r_scale_low  <= SCALE_LOW_RST;
            r_scale_mid  <= SCALE_MID_RST;
            r_scale_high <= SCALE_HIGH_RST;
            r_sat_limit  <= SAT_LIMIT_RST;
            r_down_high  <= DOWN_HIGH_RST;
            r_down_mid   <= DOWN_MID_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_AUTO_EN:    r_auto_en    <= i_cfg_wdata[0];
                REG_INIT_RANGE: ; // handled by the range unit
                REG_SCALE_LOW:  r_scale_low  <= i_cfg_wdata[SCALE_W-1:0];
                REG_SCALE_MID:  r_scale_mid  <= i_cfg_wdata[SCALE_W-1:0];
                REG_SCALE_HIGH: r_scale_high <= i_cfg_wdata[SCALE_W-1:0];
                REG_SAT_LIMIT:  r_sat_limit  <= i_cfg_wdata[LIMIT_W-1:0];
                REG_DOWN_HIGH:  r_down_high  <= i_cfg_wdata[LIMIT_W-1:0];
                REG_DOWN_MID:   r_down_mid   <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: output register frees when empty or taken
    assign w_load2    = !r_v2 || !i_out_stall;
    assign w_load1    = !r_v1 || w_load2;
    assign w_accept   = i_in_valid && w_load1;
    assign o_in_stall = !w_load1;

    assign w_ctl.load1 = w_accept;
    assign w_ctl.load2 = w_load2 && r_v1;

    always_comb begin
        case (w_range)
            RANGE_250: w_scale = r_scale_low;
            RANGE_500: w_scale = r_scale_mid;
            default:   w_scale = r_scale_high;
        endcase
    end

    assign w_down = (w_range == RANGE_2000) ? r_down_high : r_down_mid;

    assign w_raw[0] = i_in_item.x_raw;
    assign w_raw[1] = i_in_item.y_raw;
    assign w_raw[2] = i_in_item.z_raw;

    for (genvar g = 0; g < AXIS_MAX; g++) begin : g_lane
        if (g < AXIS_COUNT) begin : g_on
            gar_lane u_lane (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_raw       (w_raw[g]),
                .i_sat_limit (r_sat_limit),
                .i_down_limit(w_down),
                .i_scale     (r_scale1),
                .o_flags     (w_flags[g]),
                .o_rate      (w_rate[g])
            );
        end else begin : g_off
            // absent axis: neutral for ranging, rate reads zero
            assign w_flags[g].over_sat    = 1'b0;
            assign w_flags[g].inside_down = 1'b1;
            assign w_rate[g]              = '0;
        end
    end

    gar_range u_range (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (i_cfg_wr_en && (i_cfg_index == REG_INIT_RANGE)),
        .i_load_value(i_cfg_wdata[RANGE_W-1:0]),
        .i_accept    (w_accept),
        .i_auto_en   (r_auto_en),
        .i_flags     (w_flags),
        .o_range     (w_range),
        .o_next      (w_next),
        .o_changed   (w_changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_load1) begin
                r_v1 <= i_in_valid;
            end
            if (w_load2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load1) begin
            r_scale1   <= w_scale;
            r_used1    <= w_range;
            r_next1    <= w_next;
            r_changed1 <= w_changed;
        end
        if (w_ctl.load2) begin
            r_used2    <= r_used1;
            r_next2    <= r_next1;
            r_changed2 <= r_changed1;
        end
    end

    assign o_out_valid              = r_v2;
    assign o_out_item.x_rate        = w_rate[0];
    assign o_out_item.y_rate        = w_rate[1];
    assign o_out_item.z_rate        = w_rate[2];
    assign o_out_item.range_used    = r_used2;
    assign o_out_item.range_next    = r_next2;
    assign o_out_item.range_changed = r_changed2;

endmodule

FILE: sv/gar_checker.sv
`timescale 1ns / 1ps
`include "gyro_autorange_scaler_core_defines.svh"

module gar_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_stall,
    input  gar_pkg::t_out_item i_out_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall
);
    import gar_pkg::*;

    logic [RANGE_W-1:0] w_used;
    logic [RANGE_W-1:0] w_next;
    logic               w_chg;
    logic               w_jump;
    logic               w_legal;
    logic               w_held;

    assign w_used  = i_out_item.range_used;
    assign w_next  = i_out_item.range_next;
    assign w_chg   = i_out_item.range_changed;
    // straight jump between the two end ranges
    assign w_jump  = (w_used == RANGE_250 && w_next == RANGE_2000) ||
                     (w_used == RANGE_2000 && w_next == RANGE_250);
    assign w_legal = (w_used != RANGE_BAD) && (w_next != RANGE_BAD);
    assign w_held  = i_out_valid && i_out_stall;

    // flag must agree with the two range codes
    `GAR_ASSERT_NOW(a_changed_flag, i_clk, i_rst_n, i_out_valid, w_chg == (w_used != w_next))

    // range moves by one step at most
    `GAR_ASSERT_NOW(a_single_step, i_clk, i_rst_n, i_out_valid, !w_jump)

    // range code three never reaches the output
    `GAR_ASSERT_NOW(a_range_legal, i_clk, i_rst_n, i_out_valid, w_legal)

    // a stalled item is held
    `GAR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held, i_out_valid && $stable(i_out_item))

    // input side only stalls while the output is full and blocked
    `GAR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, i_in_stall, w_held)

endmodule

bind gyro_autorange_scaler_core gar_checker u_gar_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_stall (o_in_stall),
    .i_out_item (o_out_item),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall)
);
